@@ hw/rtl/imsd_pkg.sv @@
`default_nettype none
package imsd_pkg;

    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic        RST_SENSOR_PRESENT = 1'b0;
    localparam logic [15:0] RST_ACCEL_LIMIT    = 16'd14746;
    localparam logic [15:0] RST_GYRO_LIMIT     = 16'd16640;
    localparam logic [15:0] RST_COOLDOWN       = 16'd1200;

    // smoothing and decay gains, Q0.16
    localparam logic [21:0] K_TILT     = 22'd14418;
    localparam logic [21:0] K_SPIN     = 22'd22938;
    localparam logic [21:0] K_ATTACK   = 22'd31457;
    localparam logic [21:0] K_RELEASE  = 22'd7864;
    localparam logic [21:0] K_E_DECAY  = 22'd61604;
    localparam logic [21:0] K_S_DECAY  = 22'd53740;

    // reciprocals: /3 at 2^19, /17 at 2^24, /55 at 2^27
    localparam logic [21:0] RCP_3  = 22'd174763;
    localparam logic [21:0] RCP_17 = 22'd986896;
    localparam logic [21:0] RCP_55 = 22'd2440323;

    localparam logic [16:0] TILT_SAT   = 17'd6144;
    localparam logic [16:0] SPIN_SAT   = 17'd14080;
    localparam logic [19:0] AE_SAT     = 20'd34816;
    localparam logic [15:0] ONE_G      = 16'd8192;
    localparam logic [15:0] GYRO_FLOOR = 16'd512;
    localparam logic [14:0] MOVE_E     = 15'd2621;
    localparam logic [14:0] MOVE_E_IDLE = 15'd1966;
    localparam logic [16:0] MOVE_TILT  = 17'd5898;

    typedef enum logic [1:0] {
        OP_ABSENT,
        OP_TICK,
        OP_HOLD,
        OP_SAMPLE
    } t_op;

    typedef enum logic [1:0] {
        CFG_SENSOR_PRESENT,
        CFG_ACCEL_LIMIT,
        CFG_GYRO_LIMIT,
        CFG_COOLDOWN
    } t_cfg_idx;

    typedef struct packed {
        t_op                op;
        logic               acc_ok;
        logic               gyr_ok;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
        logic [31:0]        now;
    } t_entry;

    typedef struct packed {
        logic        sensor_present;
        logic [15:0] acc_lim;
        logic [15:0] gyr_lim;
        logic [15:0] cooldown;
    } t_cfg;

    typedef struct packed {
        logic               available;
        logic               shake;
        logic               moving;
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic signed [15:0] spin;
        logic [14:0]        energy;
        logic [31:0]        updated_time;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ASQ,
        ST_ASQRT,
        ST_RX,
        ST_TX,
        ST_RY,
        ST_TY,
        ST_AE,
        ST_GSQ,
        ST_GSQRT,
        ST_RS,
        ST_SS,
        ST_GE,
        ST_SDEC,
        ST_EDEC,
        ST_EN,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/imsd_front.sv @@
`default_nettype none
module imsd_front import imsd_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_valid, gyro_valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, now_ms
    input  wire logic [135:0] s_axis_tdata,
    // kind
    input  wire logic         s_axis_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         i_q_full,
    output logic              o_push,
    output t_entry            o_entry,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_present <= RST_SENSOR_PRESENT;
            r_cfg.acc_lim        <= RST_ACCEL_LIMIT;
            r_cfg.gyr_lim        <= RST_GYRO_LIMIT;
            r_cfg.cooldown       <= RST_COOLDOWN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SENSOR_PRESENT: r_cfg.sensor_present <= i_cfg_wdata[0];
                CFG_ACCEL_LIMIT:    r_cfg.acc_lim        <= i_cfg_wdata;
                CFG_GYRO_LIMIT:     r_cfg.gyr_lim        <= i_cfg_wdata;
                CFG_COOLDOWN:       r_cfg.cooldown       <= i_cfg_wdata;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg         = r_cfg;
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_entry.acc_ok = s_axis_tdata[0];
        o_entry.gyr_ok = s_axis_tdata[1];
        o_entry.ax     = s_axis_tdata[17:2];
        o_entry.ay     = s_axis_tdata[33:18];
        o_entry.az     = s_axis_tdata[49:34];
        o_entry.gx     = s_axis_tdata[65:50];
        o_entry.gy     = s_axis_tdata[81:66];
        o_entry.gz     = s_axis_tdata[97:82];
        o_entry.now    = s_axis_tdata[129:98];
        // sensor absence set here; user must keep config static while items flow, unchecked
        if (!r_cfg.sensor_present) begin
            o_entry.op = OP_ABSENT;
        end else if (!s_axis_tuser) begin
            o_entry.op = OP_TICK;
        end else if (!(s_axis_tdata[0] || s_axis_tdata[1])) begin
            o_entry.op = OP_HOLD;
        end else begin
            o_entry.op = OP_SAMPLE;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/imsd_queue.sv @@
`default_nettype none
module imsd_queue import imsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_entry    o_data,
    input  wire logic i_pop
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/imsd_back.sv @@
`default_nettype none
module imsd_back import imsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_q_valid,
    input  t_entry    i_q_data,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_result
);

    t_state r_state, n_state;
    t_entry r_ent, n_ent;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_v, n_v;
    logic [31:0] r_r, n_r;
    logic [15:0] r_amag, n_amag;
    logic [15:0] r_gmag, n_gmag;
    logic signed [15:0] r_raw, n_raw;
    logic [14:0] r_acc_e, n_acc_e;
    logic [14:0] r_gyr_e, n_gyr_e;
    logic signed [15:0] r_tx, n_tx;
    logic signed [15:0] r_ty, n_ty;
    logic signed [15:0] r_spin, n_spin;
    logic [14:0] r_energy, n_energy;
    t_time r_last_shake, n_last_shake;
    t_time r_last_upd, n_last_upd;
    logic r_avail, n_avail;
    logic r_moving, n_moving;
    logic r_out_valid, n_out_valid;
    t_result r_res, n_res;

    logic [20:0] mul_a;
    logic [21:0] mul_b;
    logic [42:0] prod;

    function automatic logic [16:0] mag16(input logic [15:0] x);
        logic [16:0] e;
        e = {x[15], x};
        return e[16] ? 17'(-e) : e;
    endfunction

    function automatic logic [17:0] sdiff(input logic [15:0] a, input logic [15:0] b);
        return {{2{a[15]}}, a} - {{2{b[15]}}, b};
    endfunction

    function automatic logic [17:0] mag18(input logic [17:0] d);
        return d[17] ? 18'(-d) : d;
    endfunction

    // signed delta of trunc(d*k/65536) from the product of |d| and k
    function automatic logic [17:0] qdelta(input logic [17:0] d, input logic [42:0] p);
        logic [17:0] t;
        t = {2'b00, p[31:16]};
        return d[17] ? 18'(-t) : t;
    endfunction

    logic [15:0] sq_sel;
    logic [31:0] sq_bit, sq_rb, sq_v_nx, sq_r_nx;
    logic [16:0] rmag;
    logic        rneg;
    logic [17:0] d_tx, d_ty, d_sp, d_en;
    logic [15:0] dev;
    logic [19:0] d5;
    logic [15:0] gd;
    logic [14:0] raw_e;
    t_time       now_t;
    logic        shake_hit;

    assign now_t = TIME_BITS'(r_ent.now);

    always_comb begin
        case (r_state)
            ST_ASQ:  sq_sel = (r_cnt == 4'd0) ? r_ent.ax : (r_cnt == 4'd1) ? r_ent.ay : r_ent.az;
            ST_GSQ:  sq_sel = (r_cnt == 4'd0) ? r_ent.gx : (r_cnt == 4'd1) ? r_ent.gy : r_ent.gz;
            default: sq_sel = '0;
        endcase
    end

    // one bit of the root per cycle
    assign sq_bit  = 32'd1 << (5'd30 - {r_cnt, 1'b0});
    assign sq_rb   = r_r + sq_bit;
    assign sq_v_nx = (r_v >= sq_rb) ? r_v - sq_rb : r_v;
    assign sq_r_nx = (r_v >= sq_rb) ? (r_r >> 1) + sq_bit : r_r >> 1;

    always_comb begin
        case (r_state)
            ST_RX:   rneg = r_ent.ax[15];
            ST_RY:   rneg = r_ent.ay[15];
            default: rneg = r_ent.gz[15];
        endcase
        case (r_state)
            ST_RX:   rmag = mag16(r_ent.ax);
            ST_RY:   rmag = mag16(r_ent.ay);
            default: rmag = mag16(r_ent.gz);
        endcase
    end

    assign d_tx  = sdiff(r_raw, r_tx);
    assign d_ty  = sdiff(r_raw, r_ty);
    assign d_sp  = sdiff(r_raw, r_spin);
    assign raw_e = (r_gyr_e > r_acc_e) ? r_gyr_e : r_acc_e;
    assign d_en  = {3'b000, raw_e} - {3'b000, r_energy};
    assign dev   = (r_amag >= ONE_G) ? r_amag - ONE_G : ONE_G - r_amag;
    assign d5    = ({4'b0000, dev} << 2) + {4'b0000, dev} - 20'd2048;
    assign gd    = r_gmag - GYRO_FLOOR;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_ASQ, ST_GSQ: begin
                mul_a = 21'(mag16(sq_sel));
                mul_b = 22'(mag16(sq_sel));
            end
            ST_RX, ST_RY: begin
                mul_a = {rmag, 4'b0000};
                mul_b = RCP_3;
            end
            ST_RS: begin
                mul_a = {rmag[13:0], 7'b0};
                mul_b = RCP_55;
            end
            ST_TX: begin
                mul_a = 21'(mag18(d_tx));
                mul_b = K_TILT;
            end
            ST_TY: begin
                mul_a = 21'(mag18(d_ty));
                mul_b = K_TILT;
            end
            ST_SS: begin
                mul_a = 21'(mag18(d_sp));
                mul_b = K_SPIN;
            end
            ST_AE: begin
                mul_a = {d5[16:0], 4'b0000};
                mul_b = RCP_17;
            end
            ST_GE: begin
                mul_a = {gd[13:0], 7'b0};
                mul_b = RCP_55;
            end
            ST_SDEC: begin
                mul_a = 21'(mag16(r_spin));
                mul_b = K_S_DECAY;
            end
            ST_EDEC: begin
                mul_a = 21'(r_energy);
                mul_b = K_E_DECAY;
            end
            ST_EN: begin
                mul_a = 21'(mag18(d_en));
                mul_b = (raw_e > r_energy) ? K_ATTACK : K_RELEASE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 43'(mul_a) * 43'(mul_b);

    assign shake_hit = ((r_amag > i_cfg.acc_lim) || (r_gmag > i_cfg.gyr_lim))
                       && ((now_t - r_last_shake) > TIME_BITS'(i_cfg.cooldown));

    always_comb begin
        logic [15:0] q;
        logic        big;
        logic [15:0] rawv;
        logic [17:0] sum18;
        n_state      = r_state;
        n_ent        = r_ent;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_v          = r_v;
        n_r          = r_r;
        n_amag       = r_amag;
        n_gmag       = r_gmag;
        n_raw        = r_raw;
        n_acc_e      = r_acc_e;
        n_gyr_e      = r_gyr_e;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_spin       = r_spin;
        n_energy     = r_energy;
        n_last_shake = r_last_shake;
        n_last_upd   = r_last_upd;
        n_avail      = r_avail;
        n_moving     = r_moving;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_ready;
        o_pop        = 1'b0;

        // raw tilt / spin: saturate before dividing
        q = (r_state == ST_RS) ? prod[42:27] : prod[34:19];
        big = (r_state == ST_RS) ? (rmag >= SPIN_SAT) : (rmag >= TILT_SAT);
        if (rneg) begin
            rawv = big ? 16'h8000 : 16'(-q);
        end else begin
            rawv = big ? 16'h7FFF : q;
        end
        sum18 = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_ent   = i_q_data;
                    n_acc_e = '0;
                    n_gyr_e = '0;
                    n_amag  = ONE_G;
                    n_gmag  = '0;
                    n_sum   = '0;
                    n_cnt   = '0;
                    case (i_q_data.op)
                        OP_TICK:   n_state = ST_EDEC;
                        OP_SAMPLE: n_state = i_q_data.acc_ok ? ST_ASQ :
                                             i_q_data.gyr_ok ? ST_GSQ : ST_SDEC;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_ASQ, ST_GSQ: begin
                n_sum = r_sum + prod[31:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd2) begin
                    n_state = (r_state == ST_ASQ) ? ST_ASQRT : ST_GSQRT;
                    n_v     = n_sum;
                    n_r     = '0;
                    n_cnt   = '0;
                end
            end
            ST_ASQRT, ST_GSQRT: begin
                n_v   = sq_v_nx;
                n_r   = sq_r_nx;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    if (r_state == ST_ASQRT) begin
                        n_amag  = sq_r_nx[15:0];
                        n_state = ST_RX;
                    end else begin
                        n_gmag  = sq_r_nx[15:0];
                        n_state = ST_RS;
                    end
                end
            end
            ST_RX: begin
                n_raw   = rawv;
                n_state = ST_TX;
            end
            ST_TX: begin
                sum18   = {{2{r_tx[15]}}, r_tx} + qdelta(d_tx, prod);
                n_tx    = sum18[15:0];
                n_state = ST_RY;
            end
            ST_RY: begin
                n_raw   = rawv;
                n_state = ST_TY;
            end
            ST_TY: begin
                sum18   = {{2{r_ty[15]}}, r_ty} + qdelta(d_ty, prod);
                n_ty    = sum18[15:0];
                n_state = ST_AE;
            end
            ST_AE: begin
                if (d5[19] || d5 == '0) begin
                    n_acc_e = '0;
                end else if (d5 >= AE_SAT) begin
                    n_acc_e = 15'h7FFF;
                end else begin
                    n_acc_e = prod[38:24];
                end
                n_cnt   = '0;
                n_sum   = '0;
                n_state = r_ent.gyr_ok ? ST_GSQ : ST_SDEC;
            end
            ST_RS: begin
                n_raw   = rawv;
                n_state = ST_SS;
            end
            ST_SS: begin
                sum18   = {{2{r_spin[15]}}, r_spin} + qdelta(d_sp, prod);
                n_spin  = sum18[15:0];
                n_state = ST_GE;
            end
            ST_GE: begin
                if (r_gmag <= GYRO_FLOOR) begin
                    n_gyr_e = '0;
                end else if (gd >= SPIN_SAT[15:0]) begin
                    n_gyr_e = 15'h7FFF;
                end else begin
                    n_gyr_e = prod[41:27];
                end
                n_state = ST_EN;
            end
            ST_SDEC: begin
                n_spin  = r_spin[15] ? 16'(-prod[31:16]) : prod[31:16];
                n_state = (r_ent.op == OP_TICK) ? ST_FIN : ST_EN;
            end
            ST_EDEC: begin
                n_energy = prod[30:16];
                n_state  = ST_SDEC;
            end
            ST_EN: begin
                sum18    = {3'b000, r_energy} + qdelta(d_en, prod);
                n_energy = sum18[14:0];
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                n_res.shake = 1'b0;
                case (r_ent.op)
                    OP_ABSENT: n_avail = 1'b0;
                    OP_TICK:   n_moving = (r_energy > MOVE_E_IDLE);
                    OP_SAMPLE: begin
                        if (shake_hit) begin
                            n_last_shake = now_t;
                            n_res.shake  = 1'b1;
                        end
                        n_avail    = 1'b1;
                        n_moving   = (r_energy > MOVE_E) || (mag16(r_tx) > MOVE_TILT)
                                     || (mag16(r_ty) > MOVE_TILT);
                        n_last_upd = now_t;
                    end
                    default: n_avail = r_avail;
                endcase
                n_res.available    = n_avail;
                n_res.moving       = n_moving;
                n_res.tilt_x       = r_tx;
                n_res.tilt_y       = r_ty;
                n_res.spin         = r_spin;
                n_res.energy       = r_energy;
                n_res.updated_time = 32'(n_last_upd);
                n_out_valid        = 1'b1;
                n_state            = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_tx         <= '0;
            r_ty         <= '0;
            r_spin       <= '0;
            r_energy     <= '0;
            r_last_shake <= '0;
            r_last_upd   <= '0;
            r_avail      <= 1'b0;
            r_moving     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_tx         <= n_tx;
            r_ty         <= n_ty;
            r_spin       <= n_spin;
            r_energy     <= n_energy;
            r_last_shake <= n_last_shake;
            r_last_upd   <= n_last_upd;
            r_avail      <= n_avail;
            r_moving     <= n_moving;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_cnt   <= n_cnt;
        r_sum   <= n_sum;
        r_v     <= n_v;
        r_r     <= n_r;
        r_amag  <= n_amag;
        r_gmag  <= n_gmag;
        r_raw   <= n_raw;
        r_acc_e <= n_acc_e;
        r_gyr_e <= n_gyr_e;
        r_res   <= n_res;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule
`default_nettype wire

@@ hw/rtl/imu_motion_shake_detector.sv @@
`default_nettype none
// The back end handles one item at a time: an absent-sensor or empty sample goes straight
// to the result, a tick decays energy and spin, and a sample runs its valid accel and gyro
// paths through the bit-serial square root and the single shared multiplier. It takes no
// new item until its last result has been accepted.
// A two-item queue lets input be taken while the back end works.
// Reset (i_rst_n low, synchronous) clears the smoothed state, flags, times and
// queue, and loads the registers with their default values.
module imu_motion_shake_detector import imsd_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_valid, gyro_valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, now_ms
    input  wire logic [135:0] s_axis_tdata,
    // kind
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // available, shake, moving, tilt_x_out, tilt_y_out, spin_out, energy_out, updated_time
    output logic [103:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_wdata
);

    t_entry  fr_entry, q_data;
    t_cfg    cfg;
    t_result res;
    logic    push, q_full, q_valid, pop;

    imsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (fr_entry),
        .o_cfg         (cfg)
    );

    imsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    imsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    assign m_axis_tdata = {6'b000000, res.updated_time, res.energy, res.spin,
                           res.tilt_y, res.tilt_x, res.moving, res.shake, res.available};

endmodule
`default_nettype wire
